// ===== hdl/chd_pkg.sv =====
// ----------------------------------------------------------------------------
// chd_pkg: shared constants for the canonical Huffman decoder
// Field widths, operation codes and result kinds.
// ----------------------------------------------------------------------------
`default_nettype none

package chd_pkg;

  localparam int OP_W   = 2;
  localparam int SYM_W  = 9;
  localparam int LEN_W  = 5;
  localparam int BYTE_W = 8;
  localparam int KIND_W = 2;

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_BUILD = 2'd1;
  localparam logic [OP_W-1:0] OP_BYTE  = 2'd2;

  localparam logic [KIND_W-1:0] KIND_SYM   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ERR   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BUILT = 2'd2;

  typedef struct packed {
    logic [LEN_W-1:0]  longest;
    logic [SYM_W-1:0]  sym;
    logic [KIND_W-1:0] kind;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/chd_ram.sv =====
// ----------------------------------------------------------------------------
// chd_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module chd_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [$clog2(D)-1:0] waddr_i,
  input  wire logic [W-1:0]         wdata_i,
  input  wire logic [$clog2(D)-1:0] raddr_i,
  output logic      [W-1:0]         rdata_o
);

  logic [W-1:0] mem_q [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hdl/canonical_huffman_decoder.sv =====
// ----------------------------------------------------------------------------
// canonical_huffman_decoder: bit-serial canonical MSB-first Huffman decoder
//
// Input stream: tuser carries the operation, tdata the symbol index, code
// length and data byte, tlast marks the final byte of the compressed stream.
// Output stream: tuser carries the result kind, tdata the symbol and longest
// length, tlast the last result of an input item.
// A load item stores one code length and gives no result. A build item
// sweeps the length memory twice (count pass, then sort pass) and walks the
// code lengths once, then gives one result of kind "built". A byte item is
// shifted through one bit per cycle while the pending stage can take a
// result; a completed code passes a symbol memory read before its result,
// and a byte gives up to eight results, the last one flagged with tlast.
// Items are taken one at a time; the input is ready only between items.
// Results pass a one-entry pending stage and an output register, so a stalled
// receiver holds the decoder at its next result while results wait.
// Reset clears the code lengths (per-entry valid bits), the longest length
// and the partial code, and sets alphabet_size to 258; no clearing pass.
// The configuration channel is always ready; write it only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module canonical_huffman_decoder
  import chd_pkg::*;
#(
  parameter int SYMBOLS         = 258,
  parameter int MAX_CODE_LENGTH = 20
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [8:0] symbol_index, [13:9] code_length, [21:14] data_byte, [23:22] zero
  input  wire logic [23:0] s_axis_tdata_i,
  // [1:0] operation
  input  wire logic [1:0]  s_axis_tuser_i,
  input  wire logic        s_axis_tlast_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [8:0] decoded_symbol, [13:9] longest_length, [15:14] zero
  output logic [15:0]      m_axis_tdata_o,
  // [1:0] kind
  output logic [1:0]       m_axis_tuser_o,
  output logic             m_axis_tlast_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [8:0]  cfg_data_i
);

  localparam int SIW = $clog2(SYMBOLS);            // symbol address
  localparam int CNW = $clog2(SYMBOLS + 1);        // symbol count
  localparam int LIW = $clog2(MAX_CODE_LENGTH + 1); // length index
  localparam int LCW = $clog2(MAX_CODE_LENGTH + 2); // length loop counter
  localparam int PW  = MAX_CODE_LENGTH;             // partial code
  localparam int CW  = MAX_CODE_LENGTH + CNW + 1;   // canonical code
  localparam int LD  = MAX_CODE_LENGTH + 1;
  localparam int CMW = LEN_W + 2;                  // length compare width
  localparam logic [LEN_W:0] MAXL_C = (LEN_W + 1)'(MAX_CODE_LENGTH);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_CNT   = 7'b0000010,
    ST_CODE  = 7'b0000100,
    ST_SORT  = 7'b0001000,
    ST_BIT   = 7'b0010000,
    ST_SYM   = 7'b0100000,
    ST_FLUSH = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // input fields
  logic [SYM_W-1:0]  in_sym;
  logic [LEN_W-1:0]  in_len;
  logic [BYTE_W-1:0] in_byte;
  assign in_sym  = s_axis_tdata_i[8:0];
  assign in_len  = s_axis_tdata_i[13:9];
  assign in_byte = s_axis_tdata_i[21:14];

  logic in_acc;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o = 1'b1;

  // state registers
  logic [SYM_W-1:0]  alpha_q;
  logic [SYMBOLS-1:0] lvalid_q;
  logic [CNW-1:0]    cnt_q   [LD];
  logic [CW-1:0]     first_q [LD];
  logic [CW-1:0]     last_q  [LD];
  logic [SIW-1:0]    offs_q  [LD];
  logic [SIW-1:0]    fill_q  [LD];
  logic [LEN_W-1:0]  max_q;
  logic [PW-1:0]     code_q;
  logic [LIW-1:0]    bits_q;
  logic [CNW-1:0]    s_q;
  logic              rd_v_q;
  logic [SIW-1:0]    rd_idx_q;
  logic [LCW-1:0]    l_q;
  logic [CW-1:0]     c_q;
  logic [CNW-1:0]    prev_q;
  logic [CNW-1:0]    pos_q;
  logic [BYTE_W-1:0] sh_q;
  logic [3:0]        bitcnt_q;
  logic              fin_q;
  logic              pend_v_q, out_v_q;
  res_t              pend_q, out_q;
  logic              out_last_q;
  logic [SIW-1:0]    sym_raddr_q;

  // memories
  logic [LEN_W-1:0] len_rdata;
  logic [SYM_W-1:0] sort_rdata;
  logic             len_we, sort_we;
  logic [SIW-1:0]   len_raddr, sort_waddr, sort_raddr;

  chd_ram #(.W(LEN_W), .D(SYMBOLS)) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (in_sym[SIW-1:0]),
    .wdata_i (({1'b0, in_len} > MAXL_C) ? '0 : in_len),
    .raddr_i (len_raddr),
    .rdata_o (len_rdata)
  );

  chd_ram #(.W(SYM_W), .D(SYMBOLS)) u_sort_ram (
    .clk_i   (clk_i),
    .we_i    (sort_we),
    .waddr_i (sort_waddr),
    .wdata_i (SYM_W'(rd_idx_q)),
    .raddr_i (sort_raddr),
    .rdata_o (sort_rdata)
  );

  // combinational control
  logic              slot_free, can_step;
  logic [CNW-1:0]    n_sym;
  logic              issue;
  logic [LEN_W-1:0]  len_rd;
  logic [LIW-1:0]    len_rd_ix;
  logic [LIW-1:0]    l_ix;
  logic              bit_in;
  logic [PW-1:0]     code_n;
  logic [LIW-1:0]    bits_n;
  logic              hit, at_max, code_done;
  logic              push_en, flush_en;
  res_t              push_res;
  logic [SIW-1:0]    hit_raddr;

  always_comb begin
    slot_free = !out_v_q || m_axis_tready_i;
    can_step  = !pend_v_q || slot_free;
    if ({1'b0, alpha_q} >= (SYM_W + 1)'(SYMBOLS)) begin
      n_sym = CNW'(SYMBOLS);
    end else begin
      n_sym = CNW'(alpha_q);
    end
    issue     = (s_q < n_sym) && (state_q == ST_CNT || state_q == ST_SORT);
    len_raddr = s_q[SIW-1:0];
    len_rd    = lvalid_q[rd_idx_q] ? len_rdata : '0;
    len_rd_ix = LIW'(len_rd);
    l_ix      = LIW'(l_q);
    len_we    = in_acc && (s_axis_tuser_i == OP_LOAD) &&
                ({1'b0, in_sym} < (SYM_W + 1)'(SYMBOLS));
    sort_we    = (state_q == ST_SORT) && rd_v_q && (len_rd != '0);
    sort_waddr = fill_q[len_rd_ix];

    bit_in = sh_q[BYTE_W-1];
    code_n = (code_q << 1) | PW'(bit_in);
    bits_n = bits_q + 1'b1;
    hit    = (cnt_q[bits_n] != '0) && (CW'(code_n) >= first_q[bits_n]) &&
             (CW'(code_n) <= last_q[bits_n]);
    at_max = (CMW'(bits_n) >= CMW'(max_q));
    hit_raddr  = offs_q[bits_n] + SIW'(CW'(code_n) - first_q[bits_n]);
    // hold the symbol read address while a symbol waits to be pushed
    sort_raddr = (state_q == ST_SYM) ? sym_raddr_q : hit_raddr;
    code_done  = (CMW'(l_q) > CMW'(max_q));

    push_en  = 1'b0;
    flush_en = 1'b0;
    push_res = '{longest: max_q, sym: '0, kind: KIND_ERR};
    state_d  = state_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser_i == OP_BUILD) begin
            state_d = ST_CNT;
          end else if (s_axis_tuser_i == OP_BYTE) begin
            if (max_q == '0) begin
              push_en = 1'b1;
              state_d = ST_FLUSH;
            end else begin
              state_d = ST_BIT;
            end
          end
        end
      end
      ST_CNT: begin
        if (!issue && !rd_v_q) begin
          state_d = ST_CODE;
        end
      end
      ST_CODE: begin
        if (code_done) begin
          state_d = ST_SORT;
        end
      end
      ST_SORT: begin
        if (!issue && !rd_v_q) begin
          push_en  = 1'b1;
          push_res.kind = KIND_BUILT;
          state_d  = ST_FLUSH;
        end
      end
      ST_BIT: begin
        if (can_step) begin
          if (hit) begin
            state_d = ST_SYM;
          end else begin
            push_en = at_max;
            if (bitcnt_q == 4'd7) begin
              state_d = ST_FLUSH;
            end
          end
        end
      end
      ST_SYM: begin
        if (can_step) begin
          push_en = 1'b1;
          push_res.kind = KIND_SYM;
          push_res.sym  = sort_rdata;
          state_d = (bitcnt_q == 4'd8) ? ST_FLUSH : ST_BIT;
        end
      end
      ST_FLUSH: begin
        // close an item: truncated-code error once on a final byte, then drain pending
        if (bitcnt_q == 4'd8 && fin_q && bits_q != '0) begin
          if (can_step) begin
            push_en = 1'b1;
          end
        end else if (!pend_v_q) begin
          state_d = ST_IDLE;
        end else if (slot_free) begin
          flush_en = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      alpha_q  <= 9'd258;
      lvalid_q <= '0;
      max_q    <= '0;
      code_q   <= '0;
      bits_q   <= '0;
      rd_v_q   <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      bitcnt_q <= '0;
      fin_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      sym_raddr_q <= sort_raddr;
      if (cfg_valid_i && cfg_ready_o) begin
        alpha_q <= cfg_data_i;
      end
      if (len_we) begin
        lvalid_q[in_sym[SIW-1:0]] <= 1'b1;
      end

      // length memory sweep, shared by count and sort passes
      rd_v_q <= issue;
      if (issue) begin
        rd_idx_q <= s_q[SIW-1:0];
        s_q      <= s_q + 1'b1;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc && s_axis_tuser_i == OP_BUILD) begin
            for (int i = 0; i < LD; i++) begin
              cnt_q[i] <= '0;
            end
            max_q <= '0;
            s_q   <= '0;
          end
          if (in_acc && s_axis_tuser_i == OP_BYTE) begin
            sh_q     <= in_byte;
            fin_q    <= s_axis_tlast_i;
            bitcnt_q <= '0;
            if (max_q == '0) begin
              code_q <= '0;
              bits_q <= '0;
            end
          end
        end
        ST_CNT: begin
          if (rd_v_q && len_rd != '0) begin
            cnt_q[len_rd_ix] <= cnt_q[len_rd_ix] + 1'b1;
            if (len_rd > max_q) begin
              max_q <= len_rd;
            end
          end
          l_q    <= LCW'(1);
          c_q    <= '0;
          prev_q <= '0;
          pos_q  <= '0;
        end
        ST_CODE: begin
          if (!code_done) begin
            first_q[l_ix] <= (c_q + CW'(prev_q)) << 1;
            last_q[l_ix]  <= (cnt_q[l_ix] != '0) ?
                             ((c_q + CW'(prev_q)) << 1) + CW'(cnt_q[l_ix]) - 1'b1 : '0;
            offs_q[l_ix]  <= pos_q[SIW-1:0];
            fill_q[l_ix]  <= pos_q[SIW-1:0];
            pos_q  <= pos_q + cnt_q[l_ix];
            prev_q <= cnt_q[l_ix];
            c_q    <= (c_q + CW'(prev_q)) << 1;
            l_q    <= l_q + 1'b1;
          end else begin
            s_q <= '0;
          end
        end
        ST_SORT: begin
          if (sort_we) begin
            fill_q[len_rd_ix] <= fill_q[len_rd_ix] + 1'b1;
          end
          code_q   <= '0;
          bits_q   <= '0;
          bitcnt_q <= '0;
        end
        ST_BIT: begin
          if (can_step) begin
            sh_q     <= sh_q << 1;
            bitcnt_q <= bitcnt_q + 1'b1;
            if (hit || at_max) begin
              code_q <= '0;
              bits_q <= '0;
            end else begin
              code_q <= code_n;
              bits_q <= bits_n;
            end
          end
        end
        ST_SYM: begin
        end
        ST_FLUSH: begin
          if (fin_q && bitcnt_q == 4'd8 && can_step) begin
            code_q <= '0;
            bits_q <= '0;
          end
        end
        default: begin
        end
      endcase

      // pending stage and output register
      if (push_en) begin
        pend_q   <= push_res;
        pend_v_q <= 1'b1;
      end else if (flush_en) begin
        pend_v_q <= 1'b0;
      end
      if ((push_en && pend_v_q) || flush_en) begin
        out_q      <= pend_q;
        out_last_q <= flush_en;
        out_v_q    <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {2'b00, out_q.longest, out_q.sym};
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tlast_o  = out_last_q;

  // a result never overwrites a waiting one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_en && pend_v_q) |-> slot_free)
    else $error("pending result overwritten");

  // no result waits once the block takes a new item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_v_q)
    else $error("result left pending at idle");

  // the partial code stays shorter than the longest code while decoding
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BIT) |-> (CMW'(bits_q) < CMW'(max_q)))
    else $error("partial code reached longest length");

endmodule

`default_nettype wire

// ===== tb/sv/chd_checker.sv =====
// ----------------------------------------------------------------------------
// chd_checker: result predictor and scoreboard for the Huffman decoder
// Watches the input, output and configuration channels, models the decoder
// tables and the bit-serial decode, and compares every result item in order.
// ----------------------------------------------------------------------------
`default_nettype none

module chd_checker
  import chd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  input  wire logic        s_axis_tready_i,
  input  wire logic [23:0] s_axis_tdata_i,
  input  wire logic [1:0]  s_axis_tuser_i,
  input  wire logic        s_axis_tlast_i,
  input  wire logic        m_axis_tvalid_i,
  input  wire logic        m_axis_tready_i,
  input  wire logic [15:0] m_axis_tdata_i,
  input  wire logic [1:0]  m_axis_tuser_i,
  input  wire logic        m_axis_tlast_i,
  input  wire logic        cfg_valid_i,
  input  wire logic        cfg_ready_i,
  input  wire logic [8:0]  cfg_data_i,
  output int               err_count_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSYM   = 258;
  localparam int MAXLEN = 20;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [SYM_W-1:0]  sym;
    logic [LEN_W-1:0]  longest;
    logic              last;
  } outcome_t;

  outcome_t    outcome_q[$];
  logic [4:0]  code_len[NSYM];
  logic [8:0]  symbol_order[NSYM];
  logic [63:0] first_code[MAXLEN+1];
  logic [63:0] last_code[MAXLEN+1];
  int          len_offset[MAXLEN+1];
  int          len_count[MAXLEN+1];
  int          longest;
  logic [63:0] partial;
  int          partial_bits;
  logic [8:0]  alphabet;

  task automatic report(input string what, input int expv, input int gotv);
    $display("[%0t] mismatch %s: expected %0d, got %0d", $realtime, what, expv, gotv);
    err_count_o++;
  endtask

  task automatic push_outcome(input logic [KIND_W-1:0] kind, input logic [SYM_W-1:0] sym);
    outcome_q.insert(outcome_q.size(), '{kind, sym, longest[4:0], 1'b0});
  endtask

  task automatic build_tables();
    int n;
    int pos;
    logic [63:0] c;
    logic [63:0] prev;
    n = (alphabet < NSYM) ? alphabet : NSYM;
    longest = 0;
    for (int l = 0; l <= MAXLEN; l++) begin
      len_count[l] = 0; first_code[l] = '0; last_code[l] = '0; len_offset[l] = 0;
    end
    for (int s = 0; s < n; s++) begin
      if (code_len[s] > longest) longest = code_len[s];
      if (code_len[s] != 0) len_count[code_len[s]]++;
    end
    c = '0;
    prev = '0;
    for (int l = 1; l <= longest; l++) begin
      c = (c + prev) << 1;
      first_code[l] = c;
      last_code[l] = (len_count[l] != 0) ? c + len_count[l] - 1 : '0;
      prev = len_count[l];
    end
    pos = 0;
    for (int l = 1; l <= longest; l++) begin
      len_offset[l] = pos;
      for (int s = 0; s < n; s++)
        if (code_len[s] == l && pos < NSYM) begin
          symbol_order[pos] = s[8:0];
          pos++;
        end
    end
    partial = '0;
    partial_bits = 0;
  endtask

  task automatic decode_byte(input logic [7:0] data, input logic fin);
    int k;
    int l;
    logic [63:0] idx;
    k = 0;
    if (longest == 0) begin
      partial = '0;
      partial_bits = 0;
      push_outcome(KIND_ERR, '0);
      k = 1;
    end else begin
      for (int b = 7; b >= 0; b--) begin
        partial = (partial << 1) | data[b];
        partial_bits++;
        l = partial_bits;
        if (l <= MAXLEN && len_count[l] != 0 && partial >= first_code[l] &&
            partial <= last_code[l]) begin
          idx = len_offset[l] + (partial - first_code[l]);
          push_outcome(KIND_SYM, (idx < NSYM) ? symbol_order[idx] : '0);
          k++;
          partial = '0;
          partial_bits = 0;
        end else if (l >= longest) begin
          push_outcome(KIND_ERR, '0);
          k++;
          partial = '0;
          partial_bits = 0;
        end
      end
      // final byte: flag a truncated code, then drop the partial code
      if (fin) begin
        if (partial_bits > 0 && k < 8) begin
          push_outcome(KIND_ERR, '0);
          k++;
        end
        partial = '0;
        partial_bits = 0;
      end
    end
    if (k > 0) outcome_q[outcome_q.size()-1].last = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    if (!rst_ni) begin
      for (int s = 0; s < NSYM; s++) begin
        code_len[s] = '0;
        symbol_order[s] = '0;
      end
      longest = 0;
      partial = '0;
      partial_bits = 0;
      alphabet = 9'd258;
      outcome_q.delete();
      err_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) alphabet = cfg_data_i;
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        case (s_axis_tuser_i)
          OP_LOAD: begin
            if (s_axis_tdata_i[8:0] < NSYM)
              code_len[s_axis_tdata_i[8:0]] =
                (s_axis_tdata_i[13:9] > MAXLEN) ? 5'd0 : s_axis_tdata_i[13:9];
          end
          OP_BUILD: begin
            build_tables();
            push_outcome(KIND_BUILT, '0);
            outcome_q[outcome_q.size()-1].last = 1'b1;
          end
          OP_BYTE: decode_byte(s_axis_tdata_i[21:14], s_axis_tlast_i);
          default: ;
        endcase
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (outcome_q.size() == 0) begin
          report("unexpected result, kind", -1, m_axis_tuser_i);
        end else begin
          want = outcome_q.pop_front();
          if (m_axis_tuser_i != want.kind) report("kind", want.kind, m_axis_tuser_i);
          if (m_axis_tdata_i[8:0] != want.sym) report("symbol", want.sym, m_axis_tdata_i[8:0]);
          if (m_axis_tdata_i[13:9] != want.longest)
            report("longest length", want.longest, m_axis_tdata_i[13:9]);
          if (m_axis_tlast_i != want.last) report("last", want.last, m_axis_tlast_i);
        end
      end
      pending_o = outcome_q.size();
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb_canonical_huffman_decoder.sv =====
// ----------------------------------------------------------------------------
// tb_canonical_huffman_decoder: stimulus and verdict for the Huffman decoder
// Runs directed corner items, then random phases that each load a prefix code
// (mostly complete, sometimes broken), build the tables and stream bytes, with
// random stalls on both sides. A checker module predicts and scores results.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_canonical_huffman_decoder;
  import chd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 190;
  localparam int SETTLE       = 40;     // idle cycles before a register write
  localparam int STALL_LIMIT  = 20000;  // cycles with no item moving
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i = '0;
  logic [1:0]  s_axis_tuser_i = OP_LOAD;
  logic        s_axis_tlast_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [8:0]  cfg_data_i = '0;

  int err_count;
  int pending;
  int items_sent;
  int phases;
  int ready_hold;
  int quiet_cycles;
  bit quiet;
  int used_syms[$];

  always #5 clk_i = ~clk_i;

  canonical_huffman_decoder u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  chd_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .m_axis_tuser_i  (m_axis_tuser_o),
    .m_axis_tlast_i  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .err_count_o     (err_count),
    .pending_o       (pending)
  );

  // Receiver side: stall in random bursts, never once the quiet part starts.
  always @(negedge clk_i) begin
    if (!quiet && ready_hold > 0) begin
      ready_hold--;
      m_axis_tready_i <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      ready_hold = $urandom_range(0, 15);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no item moved for %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending);
      $display("tb_canonical_huffman_decoder: done, errors");
      $finish;
    end
  end

  // Drive one input item and hold it until the block takes it. Valid stays
  // high into the next item unless a gap is inserted.
  task automatic send_item(input logic [1:0] op, input int sym, input int len,
                           input int data, input bit fin);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= {2'b00, data[7:0], len[4:0], sym[8:0]};
    s_axis_tlast_i  <= fin;
    #1;
    while (!s_axis_tready_o) begin
      @(negedge clk_i);
      #1;
    end
    @(negedge clk_i);
    items_sent++;
  endtask

  // Hold the sender until every expected result is in, then let the block
  // settle so the register can be written safely.
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_alphabet(input int size);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= size[8:0];
    #1;
    while (!cfg_ready_o) begin
      @(negedge clk_i);
      #1;
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // One random phase: clear the last code, load a fresh one, build, stream.
  // Deep phases keep splitting the longest leaf to reach the maximum length.
  task automatic code_phase(input bit deep);
    int alpha;
    int lens[$];
    int syms[$];
    int n;
    int pick;
    int nbytes;
    int cand;
    int data;
    bit dup;
    alpha = deep ? 511 : (($urandom_range(0, 3) == 0) ? 258 : $urandom_range(2, 258));
    write_alphabet(alpha);
    foreach (used_syms[i]) send_item(OP_LOAD, used_syms[i], 0, $urandom_range(0, 255), 1'b0);
    used_syms.delete();
    lens = '{1, 1};
    n = deep ? 21 : $urandom_range(2, 12);
    while (lens.size() < n) begin
      pick = deep ? lens.size() - 1 : $urandom_range(0, lens.size() - 1);
      if (lens[pick] >= 20) break;
      lens[pick]++;
      lens.insert(lens.size(), lens[pick]);
    end
    // broken codes: over-subscribed, incomplete or out-of-range lengths
    if (!deep && $urandom_range(0, 3) == 0)
      lens[$urandom_range(0, lens.size() - 1)] = $urandom_range(1, 31);
    foreach (lens[i]) begin
      do begin
        cand = (deep && i == 0) ? 257 : $urandom_range(0, 257);
        if (!deep && $urandom_range(0, 4) != 0 && alpha < 258) cand = $urandom_range(0, alpha - 1);
        dup = 1'b0;
        foreach (syms[j]) if (syms[j] == cand) dup = 1'b1;
      end while (dup);
      syms.insert(syms.size(), cand);
      send_item(OP_LOAD, cand, lens[i], $urandom_range(0, 255), $urandom_range(0, 1));
    end
    used_syms = syms;
    if ($urandom_range(0, 4) == 0) send_item(OP_UNUSED, $urandom_range(0, 511), 0, 0, 1'b0);
    if ($urandom_range(0, 4) == 0) send_item(OP_LOAD, $urandom_range(258, 511), 20, 0, 1'b0);
    send_item(OP_BUILD, $urandom_range(0, 511), $urandom_range(0, 31), $urandom_range(0, 255),
              $urandom_range(0, 1));
    nbytes = $urandom_range(3, 10);
    for (int i = 0; i < nbytes; i++) begin
      data = $urandom_range(0, 255);
      if (deep && $urandom_range(0, 1) == 0) data = 8'hFF;
      send_item(OP_BYTE, $urandom_range(0, 511), $urandom_range(0, 31), data,
                (i == nbytes - 1) || ($urandom_range(0, 5) == 0));
    end
    phases++;
  endtask

  initial begin
    items_sent = 0;
    phases = 0;
    ready_hold = 0;
    quiet = 1'b0;
    quiet_cycles = 0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty table before and after an empty build
    send_item(OP_BYTE, 0, 0, 8'hA5, 1'b0);
    send_item(OP_BUILD, 0, 0, 0, 1'b0);
    send_item(OP_BYTE, 0, 0, 8'hFF, 1'b1);
    // small complete code with top symbols; ignored index and oversize length
    send_item(OP_LOAD, 0, 1, 0, 1'b0);
    send_item(OP_LOAD, 257, 2, 0, 1'b0);
    send_item(OP_LOAD, 256, 2, 0, 1'b0);
    send_item(OP_LOAD, 511, 5, 0, 1'b0);
    send_item(OP_LOAD, 3, 31, 0, 1'b0);
    send_item(OP_UNUSED, 1, 1, 8'hFF, 1'b1);
    send_item(OP_BYTE, 0, 0, 8'h00, 1'b0);  // still empty: lengths wait for a build
    send_item(OP_BUILD, 0, 0, 0, 1'b0);
    send_item(OP_BYTE, 0, 0, 8'h00, 1'b0);  // eight symbols from one byte
    send_item(OP_BYTE, 0, 0, 8'hB6, 1'b0);
    send_item(OP_BYTE, 0, 0, 8'h01, 1'b1);  // truncated code on the final byte
    // smallest alphabet: only symbols 0 and 1 count, the rest cannot match
    write_alphabet(2);
    send_item(OP_BUILD, 0, 0, 0, 1'b0);
    send_item(OP_BYTE, 0, 0, 8'hF0, 1'b1);
    // over-subscribed length one
    write_alphabet(258);
    send_item(OP_LOAD, 1, 1, 0, 1'b0);
    send_item(OP_LOAD, 2, 1, 0, 1'b0);
    send_item(OP_LOAD, 256, 0, 0, 1'b0);
    send_item(OP_LOAD, 257, 0, 0, 1'b0);
    send_item(OP_BUILD, 0, 0, 0, 1'b0);
    send_item(OP_BYTE, 0, 0, 8'h5A, 1'b1);
    used_syms = '{0, 1, 2};

    code_phase(1'b1);
    while (items_sent < RANDOM_ITEMS) code_phase($urandom_range(0, 7) == 0);
    // last part: no stalls on either side
    quiet = 1'b1;
    code_phase(1'b0);
    code_phase(1'b1);

    drain_results();
    $display("covered %0d input items in %0d code phases, with empty, clamped and",
             items_sent, phases);
    $display("maximum-depth tables, broken codes and truncated streams");
    if (err_count == 0) begin
      $display("tb_canonical_huffman_decoder: done, clean");
    end else begin
      $display("tb_canonical_huffman_decoder: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
